>>> hw/rtl/sm83alu_pkg.sv
// Shared types, operation codes and flag positions for the SM83 execute unit.
package sm83alu_pkg;

    localparam int MODE_W = 4;
    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;
    localparam int FLAG_W = 4;

    // Flag bit positions in the packed Z N H C nibble
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 4'd0,
        MODE_ADC    = 4'd1,
        MODE_SUB    = 4'd2,
        MODE_SBC    = 4'd3,
        MODE_AND    = 4'd4,
        MODE_OR     = 4'd5,
        MODE_XOR    = 4'd6,
        MODE_CP     = 4'd7,
        MODE_INC8   = 4'd8,
        MODE_DEC8   = 4'd9,
        MODE_ADD16  = 4'd10,
        MODE_SPE8   = 4'd11,
        MODE_CB     = 4'd12,
        MODE_INC16  = 4'd13,
        MODE_DEC16  = 4'd14
    } t_mode;

    // CB opcode groups (opcode bits 7..6)
    typedef enum logic [1:0] {
        CB_SHIFT = 2'd0,
        CB_BIT   = 2'd1,
        CB_RES   = 2'd2,
        CB_SET   = 2'd3
    } t_cb_grp;

    // CB shift/rotate selector (opcode bits 5..3 in the shift group)
    typedef enum logic [2:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } t_shift_op;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [FLAG_W-1:0] t_flags;

endpackage

>>> hw/rtl/sm83alu_if.sv
// Request and response channel interfaces of the SM83 execute unit.
interface sm83alu_req_if;
    import sm83alu_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [WORD_W-1:0]   operand_a;
    logic [WORD_W-1:0]   operand_b;
    logic [FLAG_W-1:0]   flags_in;

    modport source (output valid, output mode, output operand_a, output operand_b,
                    output flags_in, input ready);
    modport sink   (input valid, input mode, input operand_a, input operand_b,
                    input flags_in, output ready);
endinterface

interface sm83alu_rsp_if;
    import sm83alu_pkg::*;

    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   result;
    logic [FLAG_W-1:0]   flags_out;
    logic                write_back;

    modport source (output valid, output result, output flags_out, output write_back,
                    input ready);
    modport sink   (input valid, input result, input flags_out, input write_back,
                    output ready);
endinterface

>>> hw/rtl/sm83_alu_and_cb_unit.sv
// Each request is held in the input register and then in the result register before it is offered
// on the response channel.
// Throughput: one request per cycle while the result register is empty or being taken; the result
// register stalls when full and not taken, and the input register then stalls only if also full.
// All work is one pass of adders, shifters and muxes between the input and result registers.
// Reset (i_rst_n low, synchronous) clears both stage valid bits; payload registers are not reset.
module sm83_alu_and_cb_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sm83alu_req_if.sink         i_req,
    sm83alu_rsp_if.source       o_rsp
);
    import sm83alu_pkg::*;

    // Input stage
    logic        r_in_valid;
    t_mode       r_mode;
    t_word       r_op_a;
    t_word       r_op_b;
    t_flags      r_flags;

    // Result stage
    logic        r_out_valid;
    t_word       r_result;
    t_flags      r_flags_out;
    logic        r_wb;

    logic        s2_en;
    logic        s1_ready;

    t_word       n_result;
    t_flags      n_flags_out;
    logic        n_wb;

    assign s2_en    = !r_out_valid || o_rsp.ready;
    assign s1_ready = !r_in_valid || s2_en;

    assign i_req.ready      = s1_ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.result     = r_result;
    assign o_rsp.flags_out  = r_flags_out;
    assign o_rsp.write_back = r_wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_in_valid <= i_req.valid;
            end
            if (s2_en) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (s1_ready && i_req.valid) begin
            r_mode  <= t_mode'(i_req.mode);
            r_op_a  <= i_req.operand_a;
            r_op_b  <= i_req.operand_b;
            r_flags <= i_req.flags_in;
        end
        if (s2_en && r_in_valid) begin
            r_result    <= n_result;
            r_flags_out <= n_flags_out;
            r_wb        <= n_wb;
        end
    end

    // Execute
    t_byte              a;
    t_byte              b;
    logic               cin;
    logic               k;
    logic [BYTE_W:0]    sum9;
    logic [4:0]         hsum5;
    logic [BYTE_W:0]    diff9;
    logic [4:0]         hdiff5;
    t_byte              logic_r;
    t_byte              inc8_r;
    t_byte              dec8_r;
    logic [WORD_W:0]    sum17;
    logic [12:0]        hsum13;
    t_word              spe8_r;
    logic [BYTE_W:0]    spe8_c9;
    logic [4:0]         spe8_h5;
    t_cb_grp            cb_grp;
    logic [2:0]         cb_sel;
    t_byte              cb_mask;
    t_byte              sh_r;
    logic               sh_c;

    always_comb begin
        a       = r_op_a[BYTE_W-1:0];
        b       = r_op_b[BYTE_W-1:0];
        cin     = r_flags[FLAG_C];
        k       = ((r_mode == MODE_ADC) || (r_mode == MODE_SBC)) ? cin : 1'b0;

        sum9    = {1'b0, a} + {1'b0, b} + {8'd0, k};
        hsum5   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, k};
        // borrow out of the top bit marks a < b + k
        diff9   = {1'b0, a} - {1'b0, b} - {8'd0, k};
        hdiff5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, k};

        inc8_r  = a + 8'd1;
        dec8_r  = a - 8'd1;

        sum17   = {1'b0, r_op_a} + {1'b0, r_op_b};
        hsum13  = {1'b0, r_op_a[11:0]} + {1'b0, r_op_b[11:0]};

        spe8_r  = r_op_a + {{8{b[7]}}, b};
        spe8_c9 = {1'b0, a} + {1'b0, b};
        spe8_h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]};

        cb_grp  = t_cb_grp'(b[7:6]);
        cb_sel  = b[5:3];
        cb_mask = t_byte'(1) << cb_sel;

        case (t_shift_op'(cb_sel))
            SH_RLC:  begin sh_c = a[7]; sh_r = {a[6:0], a[7]};   end
            SH_RRC:  begin sh_c = a[0]; sh_r = {a[0], a[7:1]};   end
            SH_RL:   begin sh_c = a[7]; sh_r = {a[6:0], cin};    end
            SH_RR:   begin sh_c = a[0]; sh_r = {cin, a[7:1]};    end
            SH_SLA:  begin sh_c = a[7]; sh_r = {a[6:0], 1'b0};   end
            SH_SRA:  begin sh_c = a[0]; sh_r = {a[7], a[7:1]};   end
            SH_SWAP: begin sh_c = 1'b0; sh_r = {a[3:0], a[7:4]}; end
            default: begin sh_c = a[0]; sh_r = {1'b0, a[7:1]};   end
        endcase

        case (r_mode)
            MODE_AND: logic_r = a & b;
            MODE_OR:  logic_r = a | b;
            default:  logic_r = a ^ b;
        endcase

        n_result    = '0;
        n_flags_out = r_flags;
        n_wb        = 1'b1;

        case (r_mode)
            MODE_ADD, MODE_ADC: begin
                n_result    = {8'd0, sum9[7:0]};
                n_flags_out = {sum9[7:0] == 8'd0, 1'b0, hsum5[4], sum9[8]};
            end
            MODE_SUB, MODE_SBC, MODE_CP: begin
                n_result    = {8'd0, diff9[7:0]};
                n_flags_out = {diff9[7:0] == 8'd0, 1'b1, hdiff5[4], diff9[8]};
                n_wb        = (r_mode != MODE_CP);
            end
            MODE_AND: begin
                n_result    = {8'd0, logic_r};
                n_flags_out = {logic_r == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            MODE_OR, MODE_XOR: begin
                n_result    = {8'd0, logic_r};
                n_flags_out = {logic_r == 8'd0, 1'b0, 1'b0, 1'b0};
            end
            MODE_INC8: begin
                n_result    = {8'd0, inc8_r};
                n_flags_out = {inc8_r == 8'd0, 1'b0, a[3:0] == 4'hF, cin};
            end
            MODE_DEC8: begin
                n_result    = {8'd0, dec8_r};
                n_flags_out = {dec8_r == 8'd0, 1'b1, a[3:0] == 4'h0, cin};
            end
            MODE_ADD16: begin
                n_result    = sum17[WORD_W-1:0];
                n_flags_out = {r_flags[FLAG_Z], 1'b0, hsum13[12], sum17[WORD_W]};
            end
            MODE_SPE8: begin
                n_result    = spe8_r;
                n_flags_out = {1'b0, 1'b0, spe8_h5[4], spe8_c9[8]};
            end
            MODE_CB: begin
                case (cb_grp)
                    CB_BIT: begin
                        n_result    = {8'd0, a};
                        n_flags_out = {!a[cb_sel], 1'b0, 1'b1, cin};
                        n_wb        = 1'b0;
                    end
                    CB_RES: n_result = {8'd0, a & ~cb_mask};
                    CB_SET: n_result = {8'd0, a | cb_mask};
                    default: begin
                        n_result    = {8'd0, sh_r};
                        n_flags_out = {sh_r == 8'd0, 1'b0, 1'b0, sh_c};
                    end
                endcase
            end
            MODE_INC16: n_result = r_op_a + 16'd1;
            MODE_DEC16: n_result = r_op_a - 16'd1;
            default: begin
                // unused code: no result, flags kept
                n_result = '0;
                n_wb     = 1'b0;
            end
        endcase
    end

endmodule
